// ----- sv/rcfr_pkg.sv -----
`default_nettype none

package rcfr_pkg;

  // frame store geometry
  localparam int unsigned STORE_DEPTH = 33;
  localparam int unsigned ADDR_W      = 6;

  // frame format
  localparam logic [7:0]        SOF_BYTE       = 8'hA1;
  localparam logic [ADDR_W-1:0] LEN_MODE_B     = 6'd27;
  localparam logic [ADDR_W-1:0] LEN_RJ01       = 6'd33;
  localparam logic [7:0]        RJ01_LEN_FIELD = 8'd30;
  localparam logic [ADDR_W-1:0] RJ01_BASE      = 6'd3;
  localparam logic [ADDR_W-1:0] RJ01_LEN_POS   = 6'd1;
  localparam logic [ADDR_W-1:0] RJ01_CRC_POS   = 6'd32;
  localparam logic [ADDR_W-1:0] CRC16_SPAN     = 6'd25;
  localparam logic [ADDR_W-1:0] CRC16_HI_POS   = 6'd25;
  localparam logic [ADDR_W-1:0] CRC16_LO_POS   = 6'd26;

  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [15:0] CRC16_MSB  = 16'h8000;
  localparam logic [7:0]  CRC8_POLY  = 8'h8C;

  // pulse conversion
  localparam logic [10:0] PULSE_SCALE  = 11'd1400;
  localparam logic [14:0] PULSE_OFFSET = 15'd800;

  // configuration
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = 1'b1;
  localparam logic [15:0]          GAP_RESET     = 16'd8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_USE,
    ST_EVAL,
    ST_HI_RD,
    ST_HI_USE,
    ST_LO_RD,
    ST_LO_USE
  } state_t;

  typedef struct packed {
    logic byte_accept;
    logic start_check;
    logic chk_consume;
    logic addr_inc;
    logic start_channels;
    logic capture_hi;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic addr_at_end;
    logic frame_good;
    logic ch_last;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC16_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC16_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = {1'b0, c[7:1]} ^ CRC8_POLY;
      end else begin
        c = {1'b0, c[7:1]};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rc_serial_frame_receiver_core.sv -----
`default_nettype none

// rc frame receiver for the mode b serial format, plain (27 bytes) or inside the
// rj01 envelope (33 bytes). each request is one received byte plus its microsecond
// arrival stamp; a gap above frame_gap_us drops any partial frame, and a frame
// starts on 0xA1 in the first position. an ordinary byte is taken while idle. the
// byte that completes a frame starts a check pass that walks the 33-entry frame
// store through its single registered read port, a read and a use state per byte,
// then an eval state judges the crcs; per channel, a read and a use state for each
// of its two bytes follow, the last one loading the result register once the
// result side is free. the byte channel opens again after eval for a bad frame,
// which gives no results, or after the final load; a good frame gives CHANNELS
// results, the final one flagged with out_last. the result register sits between
// the two sides, so a new byte can be taken while the last channel still waits.
// config (index 0 mode, index 1 frame_gap_us) is for the user to write while the
// block is idle (not enforced); the frame length follows the mode at every byte.

module rc_serial_frame_receiver_core #(
  parameter int unsigned CHANNELS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration port
  input  wire logic                             cfg_wr_en,
  input  wire logic [rcfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rcfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // byte requests
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_rx_byte,
  input  wire logic [31:0]                      in_time_us,
  // channel results
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [3:0]                       out_channel_index,
  output logic      [14:0]                      out_pulse_us,
  output logic                                  out_last
);

  rcfr_pkg::cmd_t cmd;
  rcfr_pkg::sts_t sts;

  // frame store port signals
  logic                          ram_we;
  logic [rcfr_pkg::ADDR_W-1:0]   ram_waddr;
  logic [7:0]                    ram_wdata;
  logic [rcfr_pkg::ADDR_W-1:0]   ram_raddr;
  logic [7:0]                    ram_rdata;

  // sequencer: byte intake, check pass, channel emit
  rcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // config, assembly state, crc engines, pulse scaling, result register
  rcfr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_rx_byte        (in_rx_byte),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_pulse_us      (out_pulse_us),
    .out_last          (out_last),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .cmd               (cmd),
    .sts               (sts)
  );

  // frame store, contents undefined until written
  rcfr_ram #(
    .WIDTH (8),
    .DEPTH (rcfr_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // the store is only written by an accepted byte request
  a_store_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_valid && in_ready))
    else $error("frame store written without an accepted byte");

  // the flagged final result carries the top channel index
  a_last_is_top_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_channel_index == 4'(CHANNELS - 1)))
    else $error("last flag on a channel other than the final one");

  // scaled pulse never drops below the fixed offset
  a_pulse_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pulse_us >= rcfr_pkg::PULSE_OFFSET))
    else $error("pulse width below offset");

  // no byte is taken while the check pass is walking the store
  a_no_intake_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.chk_consume |-> !in_ready)
    else $error("byte intake open during frame check");

endmodule

`default_nettype wire

// ----- sv/rcfr_ram.sv -----
`default_nettype none

module rcfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/rcfr_ctrl.sv -----
`default_nettype none

module rcfr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rcfr_pkg::sts_t sts,
  output rcfr_pkg::cmd_t      cmd
);

  rcfr_pkg::state_t state_r;
  rcfr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rcfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.byte_accept = 1'b1;
          if (sts.frame_done) begin
            cmd.start_check = 1'b1;
            state_nxt       = rcfr_pkg::ST_CHK_RD;
          end
        end
      end
      rcfr_pkg::ST_CHK_RD: state_nxt = rcfr_pkg::ST_CHK_USE;
      rcfr_pkg::ST_CHK_USE: begin
        cmd.chk_consume = 1'b1;
        cmd.addr_inc    = 1'b1;
        state_nxt = sts.addr_at_end ? rcfr_pkg::ST_EVAL : rcfr_pkg::ST_CHK_RD;
      end
      rcfr_pkg::ST_EVAL: begin
        if (sts.frame_good) begin
          cmd.start_channels = 1'b1;
          state_nxt          = rcfr_pkg::ST_HI_RD;
        end else begin
          state_nxt = rcfr_pkg::ST_IDLE;
        end
      end
      rcfr_pkg::ST_HI_RD: state_nxt = rcfr_pkg::ST_HI_USE;
      rcfr_pkg::ST_HI_USE: begin
        cmd.capture_hi = 1'b1;
        cmd.addr_inc   = 1'b1;
        state_nxt      = rcfr_pkg::ST_LO_RD;
      end
      rcfr_pkg::ST_LO_RD: state_nxt = rcfr_pkg::ST_LO_USE;
      rcfr_pkg::ST_LO_USE: begin
        // hold here until the result register can take the channel
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.addr_inc = 1'b1;
          state_nxt = sts.ch_last ? rcfr_pkg::ST_IDLE : rcfr_pkg::ST_HI_RD;
        end
      end
      default: state_nxt = rcfr_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/rcfr_dp.sv -----
`default_nettype none

module rcfr_dp #(
  parameter int unsigned CHANNELS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_wr_en,
  input  wire logic [rcfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rcfr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input payload
  input  wire logic [7:0]                          in_rx_byte,
  input  wire logic [31:0]                         in_time_us,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [3:0]                          out_channel_index,
  output logic      [14:0]                         out_pulse_us,
  output logic                                     out_last,
  // frame store
  output logic                                     ram_we,
  output logic      [rcfr_pkg::ADDR_W-1:0]         ram_waddr,
  output logic      [7:0]                          ram_wdata,
  output logic      [rcfr_pkg::ADDR_W-1:0]         ram_raddr,
  input  wire logic [7:0]                          ram_rdata,
  // controller link
  input  wire rcfr_pkg::cmd_t                      cmd,
  output rcfr_pkg::sts_t                           sts
);

  localparam logic [3:0] LAST_CH = 4'(CHANNELS - 1);

  // configuration registers
  logic        mode_r;
  logic [15:0] gap_lim_r;

  // assembly state
  logic [31:0]                   prev_time_r;
  logic [rcfr_pkg::ADDR_W-1:0]   pos_r;
  logic                          coll_r;
  logic                          rj_r;

  // check and emit
  logic [rcfr_pkg::ADDR_W-1:0]   addr_r;
  logic [3:0]                    ch_r;
  logic                          out_valid_r;
  logic [15:0]                   crc16_r;
  logic [7:0]                    crc8_r;
  logic                          crc8_ok_r;
  logic                          len_ok_r;
  logic [7:0]                    rx_hi_r;
  logic [7:0]                    rx_lo_r;
  logic [7:0]                    val_hi_r;
  logic [3:0]                    out_ch_r;
  logic [14:0]                   out_pulse_r;
  logic                          out_last_r;

  logic [31:0]                   gap;
  logic                          restart;
  logic [rcfr_pkg::ADDR_W-1:0]   pos_eff;
  logic                          coll_eff;
  logic                          coll_nxt;
  logic [rcfr_pkg::ADDR_W-1:0]   pos_inc;
  logic [rcfr_pkg::ADDR_W-1:0]   cur_len;
  logic                          done;
  logic [rcfr_pkg::ADDR_W-1:0]   base;
  logic [rcfr_pkg::ADDR_W-1:0]   frame_len;
  logic [rcfr_pkg::ADDR_W-1:0]   rel;
  logic                          in_crc16;
  logic [26:0]                   prod;
  logic [14:0]                   pulse;

  // byte acceptance: gap restart, start of frame, position update
  always_comb begin
    gap      = in_time_us - prev_time_r;
    restart  = gap > {16'h0000, gap_lim_r};
    pos_eff  = restart ? '0 : pos_r;
    coll_eff = restart ? 1'b0 : coll_r;
    coll_nxt = coll_eff | ((pos_eff == '0) && (in_rx_byte == rcfr_pkg::SOF_BYTE));
    pos_inc  = coll_nxt ? pos_eff + 6'd1 : pos_eff;
    cur_len  = mode_r ? rcfr_pkg::LEN_RJ01 : rcfr_pkg::LEN_MODE_B;
    done     = pos_inc >= cur_len;
  end

  assign ram_we    = cmd.byte_accept & coll_nxt;
  assign ram_waddr = pos_eff;
  assign ram_wdata = in_rx_byte;
  assign ram_raddr = addr_r;

  // frame layout as latched at frame end
  always_comb begin
    base      = rj_r ? rcfr_pkg::RJ01_BASE : '0;
    frame_len = rj_r ? rcfr_pkg::LEN_RJ01 : rcfr_pkg::LEN_MODE_B;
    rel       = addr_r - base;
    in_crc16  = (addr_r >= base) && (rel < rcfr_pkg::CRC16_SPAN);
  end

  always_comb begin
    prod  = 27'({val_hi_r, ram_rdata}) * 27'(rcfr_pkg::PULSE_SCALE);
    pulse = rcfr_pkg::PULSE_OFFSET + prod[26:12];
  end

  always_comb begin
    sts.frame_done  = done;
    sts.addr_at_end = addr_r == (frame_len - 6'd1);
    sts.frame_good  = (crc16_r == {rx_hi_r, rx_lo_r}) && (!rj_r || (crc8_ok_r && len_ok_r));
    sts.ch_last     = ch_r == LAST_CH;
    sts.out_free    = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      gap_lim_r   <= rcfr_pkg::GAP_RESET;
      prev_time_r <= '0;
      pos_r       <= '0;
      coll_r      <= 1'b0;
      rj_r        <= 1'b0;
      addr_r      <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          rcfr_pkg::CFG_MODE:      mode_r    <= cfg_wdata[0];
          rcfr_pkg::CFG_FRAME_GAP: gap_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.byte_accept) begin
        prev_time_r <= in_time_us;
        pos_r       <= done ? '0 : pos_inc;
        coll_r      <= done ? 1'b0 : coll_nxt;
      end
      if (cmd.start_check) begin
        rj_r   <= mode_r;
        addr_r <= '0;
      end else if (cmd.start_channels) begin
        addr_r <= base + 6'd1;
      end else if (cmd.addr_inc) begin
        addr_r <= addr_r + 6'd1;
      end
      if (cmd.start_channels) begin
        ch_r <= '0;
      end else if (cmd.load_out) begin
        ch_r <= ch_r + 4'd1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // check accumulators and result payload
  always_ff @(posedge clk) begin
    if (cmd.start_check) begin
      crc16_r   <= '0;
      crc8_r    <= '0;
      crc8_ok_r <= 1'b0;
      len_ok_r  <= 1'b0;
    end else if (cmd.chk_consume) begin
      if (rj_r && (addr_r < rcfr_pkg::RJ01_CRC_POS)) begin
        crc8_r <= rcfr_pkg::crc8_byte(crc8_r, ram_rdata);
      end
      if (rj_r && (addr_r == rcfr_pkg::RJ01_CRC_POS)) begin
        crc8_ok_r <= crc8_r == ram_rdata;
      end
      if (rj_r && (addr_r == rcfr_pkg::RJ01_LEN_POS)) begin
        len_ok_r <= ram_rdata == rcfr_pkg::RJ01_LEN_FIELD;
      end
      if (in_crc16) begin
        crc16_r <= rcfr_pkg::crc16_byte(crc16_r, ram_rdata);
      end
      if (rel == rcfr_pkg::CRC16_HI_POS) begin
        rx_hi_r <= ram_rdata;
      end
      if (rel == rcfr_pkg::CRC16_LO_POS) begin
        rx_lo_r <= ram_rdata;
      end
    end
    if (cmd.capture_hi) begin
      val_hi_r <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_ch_r    <= ch_r;
      out_pulse_r <= pulse;
      out_last_r  <= ch_r == LAST_CH;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_pulse_us      = out_pulse_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import rcfr_pkg::*;

  localparam int unsigned CHANNELS    = 12;
  localparam int unsigned SETTLE      = 200;     // covers the longest check pass (rj01)
  localparam int unsigned CYCLE_LIMIT = 200000;

  // one byte request: received byte plus its arrival stamp
  typedef struct packed {
    logic [7:0]  rx;
    logic [31:0] stamp;
  } byte_req_t;

  // one channel result as the block should report it
  typedef struct {
    logic [3:0]  ch;
    logic [14:0] pulse;
    logic        last;
  } chan_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_rx_byte = '0;
  logic [31:0]           in_time_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            out_channel_index;
  logic [14:0]           out_pulse_us;
  logic                  out_last;

  rc_serial_frame_receiver_core #(.CHANNELS(CHANNELS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_pulse_us      (out_pulse_us),
    .out_last          (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending byte requests and the channel results they should produce
  byte_req_t    byte_q[$];
  chan_result_t chan_q[$];

  // run bookkeeping
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frames_good = 0;
  int unsigned frames_bad = 0;
  int unsigned cfg_writes = 0;
  bit          steady = 1'b0;      // no idling on either side while set

  // receiver state as the block should hold it
  logic [7:0]  frame_buf [0:STORE_DEPTH-1];
  logic [5:0]  frame_pos = '0;
  logic        in_frame = 1'b0;
  logic [31:0] last_stamp = '0;
  logic        rj01_mode = 1'b0;
  logic [15:0] gap_limit = GAP_RESET;

  // stimulus builder state
  logic [7:0]  fr [0:STORE_DEPTH-1];   // frame under construction
  logic [31:0] stamp = '0;             // arrival stamp of the last queued byte
  logic [31:0] cur_gap = 32'(GAP_RESET);
  bit          clean = 1'b0;           // last sequence was a full frame, position back at 0
  bit          exact_steps = 1'b0;     // every step exactly the gap limit

  // crc-16 ccitt, msb first, one data bit at a time
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int j = 7; j >= 0; j--) begin
      fb = c[15] ^ b[j];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
    end
    return c;
  endfunction

  // dallas/maxim crc-8, reflected, lsb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int j = 0; j < 8; j++) begin
      fb = c[0] ^ b[j];
      c  = {1'b0, c[7:1]} ^ (fb ? CRC8_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic note_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // frame complete: run the crc checks and queue the channel results
  task automatic judge_frame();
    logic [7:0]  c8;
    logic [15:0] c16;
    logic [15:0] v;
    logic [31:0] scaled;
    bit          ok;
    int          base;
    chan_result_t r;
    ok   = 1'b1;
    base = 0;
    if (rj01_mode) begin
      // envelope: length field and crc-8 over everything before the crc byte
      c8 = 8'h00;
      for (int i = 0; i < RJ01_CRC_POS; i++) c8 = crc8_step(c8, frame_buf[i]);
      ok   = (frame_buf[RJ01_LEN_POS] == RJ01_LEN_FIELD) && (c8 == frame_buf[RJ01_CRC_POS]);
      base = RJ01_BASE;
    end
    if (ok) begin
      // inner mode b frame, crc stored big endian after the payload
      c16 = 16'h0000;
      for (int i = 0; i < CRC16_SPAN; i++) c16 = crc16_step(c16, frame_buf[base + i]);
      ok = (c16 == {frame_buf[base + CRC16_HI_POS], frame_buf[base + CRC16_LO_POS]});
    end
    if (!ok) begin
      frames_bad++;
    end else begin
      frames_good++;
      for (int i = 0; i < CHANNELS; i++) begin
        v       = {frame_buf[base + 1 + 2 * i], frame_buf[base + 2 + 2 * i]};
        scaled  = 32'(v) * 32'(PULSE_SCALE);
        r.ch    = 4'(i);
        r.pulse = 15'(32'(PULSE_OFFSET) + (scaled >> 12));
        r.last  = (i == CHANNELS - 1);
        chan_q.push_back(r);
      end
    end
  endtask

  // one accepted byte request
  task automatic decode_byte(input logic [7:0] b, input logic [31:0] now);
    logic [31:0] gap;
    logic [5:0]  len;
    gap        = now - last_stamp;        // modulo 2^32 on purpose
    last_stamp = now;
    // a long silence drops any partial frame
    if (gap > 32'(gap_limit)) begin
      frame_pos = '0;
      in_frame  = 1'b0;
    end
    // start of frame only in the first position, anything else while idle is dropped
    if (frame_pos == 0 && b == SOF_BYTE) in_frame = 1'b1;
    if (in_frame) begin
      if (frame_pos < STORE_DEPTH) frame_buf[frame_pos] = b;
      frame_pos = frame_pos + 6'd1;
    end
    // length follows the mode at every byte, so a mode change can end a frame early
    len = rj01_mode ? LEN_RJ01 : LEN_MODE_B;
    if (frame_pos >= len) begin
      judge_frame();
      in_frame  = 1'b0;
      frame_pos = '0;
    end
  endtask

  // config writes and accepted requests, seen at the same edge as the block sees them
  always @(posedge clk) begin : predict
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MODE:      rj01_mode = cfg_wdata[0];
          CFG_FRAME_GAP: gap_limit = cfg_wdata;
        endcase
      end
      if (in_valid && in_ready) decode_byte(in_rx_byte, in_time_us);
    end
  end

  // ---------------------------------------------------------------------------
  // driver: feeds byte requests from the queue, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    byte_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // previous request taken (or none pending): present the next one or idle
      if (byte_q.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
        req = byte_q.pop_front();
        in_valid   <= 1'b1;
        in_rx_byte <= req.rx;
        in_time_us <= req.stamp;
        bytes_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls the result side at random and checks each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    chan_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (chan_q.size() == 0) begin
          note_mismatch($sformatf("result for channel %0d with nothing expected",
                                  out_channel_index));
        end else begin
          want = chan_q.pop_front();
          results_checked++;
          if (out_channel_index !== want.ch)
            note_mismatch($sformatf("channel_index %0d, expected %0d",
                                    out_channel_index, want.ch));
          if (out_pulse_us !== want.pulse)
            note_mismatch($sformatf("pulse_us %0d on channel %0d, expected %0d",
                                    out_pulse_us, want.ch, want.pulse));
          if (out_last !== want.last)
            note_mismatch($sformatf("last %b on channel %0d, expected %b",
                                    out_last, want.ch, want.last));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b, input logic [31:0] step);
    byte_req_t req;
    stamp     = stamp + step;
    req.rx    = b;
    req.stamp = stamp;
    byte_q.push_back(req);
  endtask

  // step between bytes of one frame: never above the gap limit
  function automatic logic [31:0] frame_step();
    if (exact_steps || $urandom_range(7) == 0) return cur_gap;
    return $urandom_range(cur_gap, 0);
  endfunction

  // step before a frame: a real inter-frame silence unless exact steps are set or it chains after a full frame
  function automatic logic [31:0] lead_step();
    if (exact_steps) return cur_gap;
    if (clean && $urandom_range(3) == 0) return frame_step();
    return cur_gap + 32'd1 + $urandom_range(20000);
  endfunction

  // queue fr[lo..hi-1]; the byte at break_at arrives after a silence past the limit
  task automatic send_range(input int lo, input int hi, input int break_at);
    logic [31:0] step;
    for (int i = lo; i < hi; i++) begin
      if (i == 0)             step = lead_step();
      else if (i == break_at) step = cur_gap + 32'd1 + $urandom_range(3000);
      else                    step = frame_step();
      add_byte(fr[i], step);
    end
  endtask

  // mode b frame at base with a valid crc; extremes gives full scale, zero and mid values
  task automatic build_mode_b(input int base, input logic [7:0] head, input bit extremes);
    logic [15:0] v;
    logic [15:0] c16;
    fr[base] = head;
    for (int i = 0; i < CHANNELS; i++) begin
      if (extremes) begin
        case (i % 4)
          0:       v = 16'hFFFF;
          1:       v = 16'h0000;
          2:       v = 16'h8000;
          default: v = 16'h7FFF;
        endcase
      end else begin
        v = 16'($urandom());
      end
      fr[base + 1 + 2 * i] = v[15:8];
      fr[base + 2 + 2 * i] = v[7:0];
    end
    c16 = 16'h0000;
    for (int i = 0; i < CRC16_SPAN; i++) c16 = crc16_step(c16, fr[base + i]);
    fr[base + CRC16_HI_POS] = c16[15:8];
    fr[base + CRC16_LO_POS] = c16[7:0];
  endtask

  task automatic seal_rj01();
    logic [7:0] c8;
    c8 = 8'h00;
    for (int i = 0; i < RJ01_CRC_POS; i++) c8 = crc8_step(c8, fr[i]);
    fr[RJ01_CRC_POS] = c8;
  endtask

  task automatic build_rj01();
    fr[0]            = SOF_BYTE;
    fr[RJ01_LEN_POS] = RJ01_LEN_FIELD;
    fr[2]            = 8'($urandom());
    build_mode_b(RJ01_BASE, 8'($urandom()), 1'b0);
    fr[30]           = 8'($urandom());
    fr[31]           = 8'($urandom());
    seal_rj01();
  endtask

  // damage the frame in fr: 0 plain crc, 1 rj01 length field, 2 rj01 crc-8,
  // 3 inner crc behind a valid envelope
  task automatic corrupt_frame(input int kind);
    case (kind)
      0: fr[$urandom_range(26, 1)] ^= 8'h01 << $urandom_range(7);
      1: begin
        fr[RJ01_LEN_POS] = RJ01_LEN_FIELD + 8'(1 + $urandom_range(224));
        seal_rj01();
      end
      2: fr[RJ01_CRC_POS] ^= 8'($urandom_range(255, 1));
      default: begin
        fr[$urandom_range(29, 3)] ^= 8'h01 << $urandom_range(7);
        seal_rj01();
      end
    endcase
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_FRAME_GAP) cur_gap = 32'(val);
    cfg_writes++;
  endtask

  // all requests taken, all results back, then room for a check pass with no results
  task automatic wait_idle();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_valid || chan_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: plain mode b, gap limit 8000
    // first byte lands exactly one limit after stamp zero, every step at the limit
    exact_steps = 1'b1;
    build_mode_b(0, SOF_BYTE, 1'b1);
    send_range(0, LEN_MODE_B, -1);
    exact_steps = 1'b0;
    clean = 1'b1;
    wait_idle();

    // random gap limit, stamps just below the 32-bit wrap
    write_cfg(CFG_FRAME_GAP, 16'($urandom_range(65535, 1)));
    stamp = 32'hFFFF_F000;
    // stray bytes while idle are dropped
    add_byte(8'h5A, 32'd10);
    add_byte(8'hFF, 32'd3);
    // silence past the limit in the middle of a frame
    build_mode_b(0, SOF_BYTE, 1'b0);
    send_range(0, 12, 10);
    clean = 1'b0;
    // one flipped bit fails the crc-16
    build_mode_b(0, SOF_BYTE, 1'b0);
    corrupt_frame(0);
    send_range(0, LEN_MODE_B, -1);
    clean = 1'b1;
    wait_idle();

    // rj01 with the tightest gap limit: every byte within a frame shares one stamp
    // no idling on either side through each way of damaging the envelope
    steady = 1'b1;
    write_cfg(CFG_MODE, 16'd1);
    write_cfg(CFG_FRAME_GAP, 16'd0);
    for (int kind = 1; kind <= 3; kind++) begin
      build_rj01();
      corrupt_frame(kind);
      send_range(0, LEN_RJ01, -1);
    end
    wait_idle();
    steady = 1'b0;
    // rj01 -> mode b with 29 bytes in: the next byte closes a 27-byte frame
    build_mode_b(0, SOF_BYTE, 1'b0);
    fr[27] = 8'($urandom());
    fr[28] = 8'($urandom());
    fr[29] = 8'($urandom());
    send_range(0, 29, -1);
    wait_idle();
    write_cfg(CFG_MODE, 16'd0);
    send_range(29, 30, -1);
    clean = 1'b1;
    // mode b -> rj01 with 20 bytes in: the frame runs on to 33
    build_rj01();
    send_range(0, 20, -1);
    wait_idle();
    write_cfg(CFG_MODE, 16'd1);
    send_range(20, LEN_RJ01, -1);
    clean = 1'b1;
    wait_idle();

    $display("%0d bytes sent across %0d register writes, plain and rj01 framing",
             bytes_sent, cfg_writes);
    $display("%0d frames decoded, %0d rejected, %0d channel results checked",
             frames_good, frames_bad, results_checked);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("no progress after %0d cycles, %0d results still expected",
             cycle_cnt, chan_q.size());
    $display("testbench failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/rcfr_pkg.sv
sv/rcfr_ram.sv
sv/rcfr_ctrl.sv
sv/rcfr_dp.sv
sv/rc_serial_frame_receiver_core.sv
test/testbench.sv
